FILE: rtl/gtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, codes and defaults of the glyph text rasterizer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  // Default sizes of the glyph table, bitmap store and glyph box
  localparam int GLYPH_SLOTS_DEF   = 256;
  localparam int BITMAP_BYTES_DEF  = 4096;
  localparam int MAX_GLYPH_DIM_DEF = 32;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // Configuration register reset values
  localparam logic [7:0]  FIRST_CODE_RST   = 8'd32;
  localparam logic [7:0]  LAST_CODE_RST    = 8'd126;
  localparam logic [7:0]  LINE_ADVANCE_RST = 8'd8;
  localparam logic [3:0]  SCALE_Y_RST      = 4'd1;
  localparam logic [31:0] INK_COLOR_RST    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_LOAD_GLYPH = 2'd0,
    CMD_LOAD_BYTE  = 2'd1,
    CMD_SET_PEN    = 2'd2,
    CMD_DRAW       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_FIRST_CODE   = 3'd0,
    CFG_LAST_CODE    = 3'd1,
    CFG_LINE_ADVANCE = 3'd2,
    CFG_SCALE_X      = 3'd3,
    CFG_SCALE_Y      = 3'd4,
    CFG_INK_COLOR    = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_REC,
    S_OFF,
    S_ROW,
    S_FILL,
    S_SOLO
  } state_t;

  typedef struct packed {
    logic [11:0] offset;
    logic [5:0]  width;
    logic [5:0]  height;
    logic [7:0]  advance;
    logic [7:0]  dx;
    logic [7:0]  dy;
  } glyph_rec_t;

  localparam int GLYPH_REC_W = $bits(glyph_rec_t);

  // Sequencer to row unit
  typedef struct packed {
    logic start_row;
    logic clear_stream;
    logic load_byte;
    logic step;
  } row_ctl_t;

  // Row unit to sequencer
  typedef struct packed {
    logic need_byte;
    logic row_done;
  } row_stat_t;

endpackage

FILE: rtl/glyph_text_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_rasterizer
// Proportional bitmap-font text engine: glyph table and bitmap store loads,
// pen placement, and one row transaction per glyph row for drawn characters.
// ----------------------------------------------------------------------------
// Loads and pen moves are done in S_IDLE; a code outside the range goes through S_SOLO.
// A drawn glyph passes S_SLOT (wrap passes of the slot index), S_REC and S_OFF (wrap
// passes of the start offset), then per row S_ROW, with S_FILL for each bitmap byte
// fetched; a row may start on bits left by the row before. Output stalls hold S_ROW and S_SOLO.
// Throughput: one transaction at a time; the output register frees the input side.
// Sync reset: state idle, pen and output valid cleared, configuration registers at defaults; stores undefined.
module glyph_text_rasterizer
  import gtr_pkg::*;
#(
  parameter int GLYPH_SLOTS   = GLYPH_SLOTS_DEF,
  parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF,
  parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [11:0]        in_table_index,
  input  logic [11:0]        in_glyph_offset,
  input  logic [5:0]         in_glyph_width,
  input  logic [5:0]         in_glyph_height,
  input  logic [7:0]         in_glyph_advance,
  input  logic signed [7:0]  in_glyph_dx,
  input  logic signed [7:0]  in_glyph_dy,
  input  logic [7:0]         in_byte_value,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [7:0]         in_char_code,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [15:0] out_row_x,
  output logic signed [15:0] out_row_y,
  output logic [31:0]        out_row_mask,
  output logic [31:0]        out_ink,
  output logic signed [15:0] out_pen_x,
  output logic signed [15:0] out_pen_y,
  output logic               out_last
);

  localparam int SW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int RW = ((AW > 12) ? AW : 12) + 1;

  // configuration registers
  logic [7:0]  first_r, last_r, line_adv_r;
  logic [3:0]  scale_y_r;
  logic [31:0] ink_r;

  state_t state_r, state_nxt;

  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [RW-1:0] off_r, off_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [5:0]  w_r, w_nxt;
  logic [5:0]  h_r, h_nxt;
  logic [5:0]  row_cnt_r, row_cnt_nxt;
  logic [15:0] row_x_r, row_x_nxt;
  logic [15:0] row_y_r, row_y_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [15:0] out_row_x_r, out_row_x_nxt;
  logic [15:0] out_row_y_r, out_row_y_nxt;
  logic [31:0] out_mask_r, out_mask_nxt;
  logic [31:0] out_ink_r, out_ink_nxt;
  logic [15:0] out_pen_x_r, out_pen_x_nxt;
  logic [15:0] out_pen_y_r, out_pen_y_nxt;
  logic        out_last_r, out_last_nxt;

  // memories
  logic                   glyph_we, glyph_re;
  logic [SW-1:0]          glyph_waddr;
  glyph_rec_t             glyph_wrec, glyph_rrec;
  logic [GLYPH_REC_W-1:0] glyph_rdata;
  logic                   bmp_we, bmp_re;
  logic [AW-1:0]          bmp_waddr;
  logic [7:0]             bmp_rdata;
  logic [16:0]            idx_ext;

  row_ctl_t    row_ctl;
  row_stat_t   row_stat;
  logic [31:0] row_mask;

  logic               out_free;
  logic [5:0]         w_clamp, h_clamp;
  logic signed [12:0] dy_prod;
  logic               row_last;

  gtr_ram #(
    .WIDTH (GLYPH_REC_W),
    .DEPTH (GLYPH_SLOTS)
  ) u_glyph_table (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (glyph_waddr),
    .wdata (glyph_wrec),
    .re    (glyph_re),
    .raddr (slot_r[SW-1:0]),
    .rdata (glyph_rdata)
  );

  gtr_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap_store (
    .clk   (clk),
    .we    (bmp_we),
    .waddr (bmp_waddr),
    .wdata (in_byte_value),
    .re    (bmp_re),
    .raddr (addr_r),
    .rdata (bmp_rdata)
  );

  gtr_row_unit u_row_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (row_ctl),
    .width   (w_r),
    .rd_byte (bmp_rdata),
    .stat    (row_stat),
    .mask    (row_mask)
  );

  assign idx_ext     = {5'b00000, in_table_index};
  assign glyph_waddr = in_table_index[SW-1:0];
  assign bmp_waddr   = idx_ext[AW-1:0];

  always_comb begin
    glyph_wrec.offset  = in_glyph_offset;
    glyph_wrec.width   = in_glyph_width;
    glyph_wrec.height  = in_glyph_height;
    glyph_wrec.advance = in_glyph_advance;
    glyph_wrec.dx      = in_glyph_dx;
    glyph_wrec.dy      = in_glyph_dy;
  end

  assign glyph_rrec = glyph_rec_t'(glyph_rdata);
  assign w_clamp = (glyph_rrec.width > 6'(MAX_GLYPH_DIM)) ? 6'(MAX_GLYPH_DIM)
                                                          : glyph_rrec.width;
  assign h_clamp = (glyph_rrec.height > 6'(MAX_GLYPH_DIM)) ? 6'(MAX_GLYPH_DIM)
                                                           : glyph_rrec.height;
  assign dy_prod  = $signed(glyph_rrec.dy) * $signed({1'b0, scale_y_r});
  assign out_free = !out_valid_r || out_ready;
  assign row_last = (row_cnt_r + 6'd1) == h_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    addr_nxt      = addr_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    row_cnt_nxt   = row_cnt_r;
    row_x_nxt     = row_x_r;
    row_y_nxt     = row_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_row_x_nxt = out_row_x_r;
    out_row_y_nxt = out_row_y_r;
    out_mask_nxt  = out_mask_r;
    out_ink_nxt   = out_ink_r;
    out_pen_x_nxt = out_pen_x_r;
    out_pen_y_nxt = out_pen_y_r;
    out_last_nxt  = out_last_r;
    glyph_we      = 1'b0;
    glyph_re      = 1'b0;
    bmp_we        = 1'b0;
    bmp_re        = 1'b0;
    row_ctl       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_cmd))
            CMD_LOAD_GLYPH: glyph_we = (in_table_index < 12'(GLYPH_SLOTS));
            CMD_LOAD_BYTE:  bmp_we   = (idx_ext < 17'(BITMAP_BYTES));
            CMD_SET_PEN: begin
              pen_x_nxt = in_pos_x;
              pen_y_nxt = in_pos_y;
            end
            CMD_DRAW: begin
              if (in_char_code < first_r || in_char_code > last_r) begin
                if (in_char_code == NEWLINE_CODE) begin
                  pen_x_nxt = 16'h0000;
                  pen_y_nxt = pen_y_r + {8'h00, line_adv_r};
                end
                state_nxt = S_SOLO;
              end else begin
                slot_nxt  = in_char_code - first_r;
                state_nxt = S_SLOT;
              end
            end
            default: ;
          endcase
        end
      end

      S_SLOT: begin
        // fold the glyph index into the table, one pass a cycle
        if ({1'b0, slot_r} >= 9'(GLYPH_SLOTS)) begin
          slot_nxt = slot_r - 8'(GLYPH_SLOTS);
        end else begin
          glyph_re  = 1'b1;
          state_nxt = S_REC;
        end
      end

      S_REC: begin
        w_nxt       = w_clamp;
        h_nxt       = h_clamp;
        off_nxt     = RW'(glyph_rrec.offset);
        row_x_nxt   = pen_x_r + {{8{glyph_rrec.dx[7]}}, glyph_rrec.dx};
        row_y_nxt   = pen_y_r + {{3{dy_prod[12]}}, dy_prod};
        pen_x_nxt   = pen_x_r + {8'h00, glyph_rrec.advance};
        row_cnt_nxt = 6'd0;
        state_nxt   = (h_clamp == 6'd0) ? S_SOLO : S_OFF;
      end

      S_OFF: begin
        if (off_r >= RW'(BITMAP_BYTES)) begin
          off_nxt = off_r - RW'(BITMAP_BYTES);
        end else begin
          addr_nxt             = off_r[AW-1:0];
          row_ctl.start_row    = 1'b1;
          row_ctl.clear_stream = 1'b1;
          state_nxt            = S_ROW;
        end
      end

      S_ROW: begin
        priority if (row_stat.row_done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = 1'b1;
            out_row_x_nxt = row_x_r;
            out_row_y_nxt = row_y_r;
            out_mask_nxt  = row_mask;
            out_ink_nxt   = ink_r;
            out_pen_x_nxt = pen_x_r;
            out_pen_y_nxt = pen_y_r;
            out_last_nxt  = row_last;
            if (row_last) begin
              state_nxt = S_IDLE;
            end else begin
              row_cnt_nxt       = row_cnt_r + 6'd1;
              row_y_nxt         = row_y_r + {12'h000, scale_y_r};
              row_ctl.start_row = 1'b1;
            end
          end
        end else if (row_stat.need_byte) begin
          bmp_re    = 1'b1;
          addr_nxt  = (addr_r == AW'(BITMAP_BYTES - 1)) ? '0 : addr_r + 1'b1;
          state_nxt = S_FILL;
        end else begin
          row_ctl.step = 1'b1;
        end
      end

      S_FILL: begin
        row_ctl.load_byte = 1'b1;
        row_ctl.step      = 1'b1;
        state_nxt         = S_ROW;
      end

      S_SOLO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_row_x_nxt = 16'h0000;
          out_row_y_nxt = 16'h0000;
          out_mask_nxt  = 32'h0;
          out_ink_nxt   = 32'h0;
          out_pen_x_nxt = pen_x_r;
          out_pen_y_nxt = pen_y_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= 16'h0000;
      pen_y_r     <= 16'h0000;
      out_valid_r <= 1'b0;
      first_r     <= FIRST_CODE_RST;
      last_r      <= LAST_CODE_RST;
      line_adv_r  <= LINE_ADVANCE_RST;
      scale_y_r   <= SCALE_Y_RST;
      ink_r       <= INK_COLOR_RST;
    end else begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FIRST_CODE:   first_r    <= cfg_wdata[7:0];
          CFG_LAST_CODE:    last_r     <= cfg_wdata[7:0];
          CFG_LINE_ADVANCE: line_adv_r <= cfg_wdata[7:0];
          CFG_SCALE_X:      ;  // column scale writes are ignored in this block
          CFG_SCALE_Y:      scale_y_r  <= cfg_wdata[3:0];
          CFG_INK_COLOR:    ink_r      <= cfg_wdata;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    off_r       <= off_nxt;
    addr_r      <= addr_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    row_cnt_r   <= row_cnt_nxt;
    row_x_r     <= row_x_nxt;
    row_y_r     <= row_y_nxt;
    out_kind_r  <= out_kind_nxt;
    out_row_x_r <= out_row_x_nxt;
    out_row_y_r <= out_row_y_nxt;
    out_mask_r  <= out_mask_nxt;
    out_ink_r   <= out_ink_nxt;
    out_pen_x_r <= out_pen_x_nxt;
    out_pen_y_r <= out_pen_y_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_row_x    = $signed(out_row_x_r);
  assign out_row_y    = $signed(out_row_y_r);
  assign out_row_mask = out_mask_r;
  assign out_ink      = out_ink_r;
  assign out_pen_x    = $signed(out_pen_x_r);
  assign out_pen_y    = $signed(out_pen_y_r);
  assign out_last     = out_last_r;

endmodule

FILE: rtl/gtr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/gtr_row_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_row_unit
// Shift unit: moves up to one byte of the MSB-first glyph bit
// stream into the row mask per step. Leftover bits carry into the next row.
// ----------------------------------------------------------------------------
module gtr_row_unit
  import gtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  row_ctl_t    ctl,
  input  logic [5:0]  width,
  input  logic [7:0]  rd_byte,
  output row_stat_t   stat,
  output logic [31:0] mask
);

  logic [7:0]  bits_r, bits_nxt;
  logic [3:0]  avail_r, avail_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [31:0] mask_r, mask_nxt;

  logic [7:0]  src_byte;
  logic [3:0]  src_avail;
  logic [5:0]  remain;
  logic [3:0]  take;
  logic [7:0]  rev;
  logic [7:0]  field;
  logic [31:0] placed;

  always_comb begin
    src_byte  = ctl.load_byte ? rd_byte : bits_r;
    src_avail = ctl.load_byte ? 4'd8 : avail_r;
    remain    = width - col_r;
    take      = ({2'b00, src_avail} < remain) ? src_avail : remain[3:0];
    // first stream bit lands in the lowest column
    for (int i = 0; i < 8; i++) begin
      rev[i] = src_byte[7-i];
    end
    field  = rev & 8'((9'h001 << take) - 9'h001);
    placed = {24'h000000, field} << col_r[4:0];
  end

  always_comb begin
    bits_nxt  = bits_r;
    avail_nxt = avail_r;
    col_nxt   = col_r;
    mask_nxt  = mask_r;
    if (ctl.start_row) begin
      col_nxt  = 6'd0;
      mask_nxt = 32'h0;
    end
    if (ctl.clear_stream) begin
      avail_nxt = 4'd0;
    end
    if (ctl.step) begin
      mask_nxt  = mask_r | placed;
      col_nxt   = col_r + {2'b00, take};
      bits_nxt  = src_byte << take;
      avail_nxt = src_avail - take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= 4'd0;
      col_r   <= 6'd0;
    end else begin
      avail_r <= avail_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    mask_r <= mask_nxt;
  end

  assign stat.row_done  = (col_r == width);
  assign stat.need_byte = (avail_r == 4'd0) && (col_r != width);
  assign mask           = mask_r;

endmodule
